FILE: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, the setup record passed from the front end to the pixel
// stepper, and the coordinate clamp.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_RANGE = 64;
    localparam int COORD_W     = 6;
    localparam int VALUE_W     = 8;
    localparam int DEC_W       = 10;
    localparam int STEP_W      = 9;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_RANGE - 1);

    typedef logic [COORD_W-1:0] coord_t;

    // Everything the stepper needs to draw one line.
    typedef struct packed {
        coord_t                    a_start;
        coord_t                    b_start;
        coord_t                    a_end;
        logic                      major_is_y;
        logic                      minor_falls;
        logic signed [DEC_W-1:0]   decision;
        logic signed [STEP_W-1:0]  step_straight;
        logic signed [STEP_W-1:0]  step_diag_up;
        logic signed [STEP_W-1:0]  step_diag_down;
        logic [VALUE_W-1:0]        line_value;
    } line_setup_t;

    // Handshake between two stages that carry a setup record.
    typedef struct packed {
        logic        valid;
        line_setup_t setup;
    } setup_chan_t;

    function automatic coord_t clamp_coord(input coord_t v);
        clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

endpackage

FILE: rtl/lr_front.sv
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Registers one request, clamps the endpoints, picks the major axis and the
// drawing direction, and works out the midpoint decision terms.
// ----------------------------------------------------------------------------
module lr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], gray_level[31:24]
    input  logic [lr_pkg::S_DATA_W-1:0]   s_tdata,
    output lr_pkg::setup_chan_t           push,
    input  logic                          push_ready
);
    import lr_pkg::*;

    logic                  hold_valid_reg, hold_valid_next;
    logic [S_DATA_W-1:0]   hold_data_reg;
    logic                  push_fire;

    coord_t                x0, y0, x1, y1;
    logic signed [6:0]     dx, dy, adx, ady;
    logic                  major_is_y, swap;
    coord_t                a0, b0, a1, b1;
    logic signed [6:0]     big, small_span;
    logic signed [DEC_W-1:0] big_w, small2_w, dec_w, up_w, down_w;

    assign push_fire       = hold_valid_reg && push_ready;
    assign s_tready        = !hold_valid_reg || push_ready;
    assign hold_valid_next = (s_tvalid && s_tready) ? 1'b1 :
                             (push_fire ? 1'b0 : hold_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        if (s_tvalid && s_tready) begin
            hold_data_reg <= s_tdata;
        end
    end

    always_comb begin
        x0 = clamp_coord(hold_data_reg[5:0]);
        y0 = clamp_coord(hold_data_reg[11:6]);
        x1 = clamp_coord(hold_data_reg[17:12]);
        y1 = clamp_coord(hold_data_reg[23:18]);
        dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
        dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
        adx = dx[6] ? -dx : dx;
        ady = dy[6] ? -dy : dy;
        // Comparing magnitudes is the same as comparing squares; ties go to y.
        major_is_y = !(adx > ady);
        swap = major_is_y ? (y1 < y0) : (x1 < x0);
        if (!major_is_y) begin
            a0 = swap ? x1 : x0;
            a1 = swap ? x0 : x1;
            b0 = swap ? y1 : y0;
            b1 = swap ? y0 : y1;
        end else begin
            a0 = swap ? y1 : y0;
            a1 = swap ? y0 : y1;
            b0 = swap ? x1 : x0;
            b1 = swap ? x0 : x1;
        end
        big        = $signed({1'b0, a1}) - $signed({1'b0, a0});
        small_span = $signed({1'b0, b1}) - $signed({1'b0, b0});
        big_w      = DEC_W'(big);
        small2_w   = DEC_W'(small_span) <<< 1;
        dec_w      = small_span[6] ? (small2_w + big_w) : (small2_w - big_w);
        up_w       = small2_w - (big_w <<< 1);
        down_w     = small2_w + (big_w <<< 1);
    end

    always_comb begin
        push.valid                = hold_valid_reg;
        push.setup.a_start        = a0;
        push.setup.b_start        = b0;
        push.setup.a_end          = a1;
        push.setup.major_is_y     = major_is_y;
        push.setup.minor_falls    = small_span[6];
        push.setup.decision       = dec_w;
        push.setup.step_straight  = small2_w[STEP_W-1:0];
        push.setup.step_diag_up   = up_w[STEP_W-1:0];
        push.setup.step_diag_down = down_w[STEP_W-1:0];
        push.setup.line_value     = hold_data_reg[31:24];
    end

endmodule

FILE: rtl/lr_queue.sv
// ----------------------------------------------------------------------------
// Line rasterizer setup queue
// A short register queue of setup records between the front end and the
// stepper, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module lr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lr_pkg::setup_chan_t   push,
    output logic                  push_ready,
    output lr_pkg::setup_chan_t   pop,
    input  logic                  pop_ready
);
    import lr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    line_setup_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.setup  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.setup;
        end
    end

endmodule

FILE: rtl/lr_back.sv
// ----------------------------------------------------------------------------
// Line rasterizer stepper
// Loads one setup record and walks the midpoint run, one pixel per cycle,
// into an output register that holds while the sink stalls.
// ----------------------------------------------------------------------------
module lr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lr_pkg::setup_chan_t           pop,
    output logic                          pop_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_value[19:12], zero[23:20]
    output logic [lr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import lr_pkg::*;

    logic                    active_reg, active_next;
    coord_t                  a_reg, b_reg, a_end_reg;
    logic                    major_is_y_reg, minor_falls_reg;
    logic signed [DEC_W-1:0] dec_reg;
    logic signed [STEP_W-1:0] st_reg, up_reg, down_reg;
    logic [VALUE_W-1:0]      value_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]     out_data_reg;
    logic                    out_last_reg;

    logic                    emit, is_last, dec_le_zero;
    logic signed [DEC_W-1:0] dec_next;
    coord_t                  b_next;
    coord_t                  px, py;

    assign pop_ready   = !active_reg;
    assign emit        = active_reg && (!out_valid_reg || m_tready);
    // The run length never exceeds the tile, so reaching the end coordinate
    // is the only way a run finishes.
    assign is_last     = (a_reg == a_end_reg);
    assign dec_le_zero = dec_reg[DEC_W-1] || (dec_reg == '0);
    assign px          = major_is_y_reg ? b_reg : a_reg;
    assign py          = major_is_y_reg ? a_reg : b_reg;

    always_comb begin
        dec_next = dec_reg;
        b_next   = b_reg;
        if (!minor_falls_reg) begin
            if (dec_le_zero) begin
                dec_next = dec_reg + DEC_W'(st_reg);
            end else begin
                dec_next = dec_reg + DEC_W'(up_reg);
                b_next   = b_reg + 1'b1;
            end
        end else begin
            if (dec_le_zero) begin
                dec_next = dec_reg + DEC_W'(down_reg);
                b_next   = b_reg - 1'b1;
            end else begin
                dec_next = dec_reg + DEC_W'(st_reg);
            end
        end
    end

    always_comb begin
        active_next = active_reg;
        if (pop.valid && pop_ready) begin
            active_next = 1'b1;
        end else if (emit && is_last) begin
            active_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
        if (pop.valid && pop_ready) begin
            a_reg           <= pop.setup.a_start;
            b_reg           <= pop.setup.b_start;
            a_end_reg       <= pop.setup.a_end;
            major_is_y_reg  <= pop.setup.major_is_y;
            minor_falls_reg <= pop.setup.minor_falls;
            dec_reg         <= pop.setup.decision;
            st_reg          <= pop.setup.step_straight;
            up_reg          <= pop.setup.step_diag_up;
            down_reg        <= pop.setup.step_diag_down;
            value_reg       <= pop.setup.line_value;
        end else if (emit && !is_last) begin
            a_reg   <= a_reg + 1'b1;
            b_reg   <= b_next;
            dec_reg <= dec_next;
        end
        if (emit) begin
            out_data_reg <= {4'b0000, value_reg, py, px};
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// Line rasterizer
// Midpoint line drawing: one request in, every pixel of the line out.
// ----------------------------------------------------------------------------
// Each request transaction carries two endpoints and a gray level; the block
// returns one transaction per pixel, starting at the endpoint with the smaller
// major coordinate, with tlast on the final pixel. A line of
// n = max(|dx|, |dy|) + 1 pixels (1 to 64) leaves the stepper at one pixel per
// cycle while the sink accepts them; the stepper loads the next line's setup
// only once the current line is done, so it takes no new line mid-run. The
// front end takes and prepares the following requests meanwhile and queues
// up to two of them. A request passes through the front-end register, the
// queue, the stepper's setup registers and the output register.
module line_rasterizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], gray_level[31:24]
    input  logic [lr_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_value[19:12], zero[23:20]
    output logic [lr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import lr_pkg::*;

    setup_chan_t push, pop;
    logic        push_ready, pop_ready;

    lr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready)
    );

    lr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    lr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop       (pop),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/lr_checker.sv
// ----------------------------------------------------------------------------
// Line rasterizer checker
// Port-level checks on the pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lr_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                          m_tlast
);
    import lr_pkg::*;

    logic pix_fire;
    assign pix_fire = m_tvalid && m_tready;

    // No pixel may be offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("pixel offered straight after reset");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pixel withdrawn while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel changed while stalled");

    // Within a line the gray level does not change from pixel to pixel.
    a_same_value: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_fire && !m_tlast ##1 m_tvalid |-> m_tdata[19:12] == $past(m_tdata[19:12]))
        else $error("gray level changed within a line");

    // Consecutive pixels of a line are neighbours in x.
    a_adjacent_x: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_fire && !m_tlast ##1 m_tvalid |->
            (m_tdata[5:0] == $past(m_tdata[5:0])) ||
            (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1) ||
            (m_tdata[5:0] == $past(m_tdata[5:0]) - 6'd1))
        else $error("pixel x jumped within a line");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
